// File: hdl/pbpm_pkg.sv
`timescale 1ns / 1ps
package pbpm_pkg;

  localparam int POOL_FRAMES_DEF = 16;
  localparam int PIN_BITS_DEF = 16;

  localparam logic [2:0] CMD_NEW    = 3'd0;
  localparam logic [2:0] CMD_FETCH  = 3'd1;
  localparam logic [2:0] CMD_UNPIN  = 3'd2;
  localparam logic [2:0] CMD_DELETE = 3'd3;
  localparam logic [2:0] CMD_FLUSH  = 3'd4;
  localparam logic [2:0] CMD_FLALL  = 3'd5;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_REPLY = 2'd2;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_NO_FRAME  = 3'd1;
  localparam logic [2:0] STS_NOT_RES   = 3'd2;
  localparam logic [2:0] STS_PINNED    = 3'd3;
  localparam logic [2:0] STS_NOT_PIN   = 3'd4;
  localparam logic [2:0] STS_EXHAUSTED = 3'd5;

  localparam logic [2:0] ESEL_WB    = 3'd0;
  localparam logic [2:0] ESEL_REQ   = 3'd1;
  localparam logic [2:0] ESEL_FLUSH = 3'd2;
  localparam logic [2:0] ESEL_SCAN  = 3'd3;
  localparam logic [2:0] ESEL_REPLY = 3'd4;

  localparam logic [1:0] PSEL_ZERO = 2'd0;
  localparam logic [1:0] PSEL_IN   = 2'd1;
  localparam logic [1:0] PSEL_INST = 2'd2;

  localparam logic [1:0] FSEL_ZERO = 2'd0;
  localparam logic [1:0] FSEL_HIT  = 2'd1;
  localparam logic [1:0] FSEL_VIC  = 2'd2;

  localparam logic [0:0] CFG_COUNT  = 1'b0;
  localparam logic [0:0] CFG_NUMBER = 1'b1;

  typedef struct packed {
    logic       load_in;
    logic       lookup;
    logic       take;
    logic       emit;
    logic [2:0] esel;
    logic       op_hit;
    logic       op_unpin;
    logic       op_delete;
    logic       scan_clr;
    logic       scan_inc;
    logic [2:0] rstatus;
    logic [1:0] psel;
    logic [1:0] fsel;
  } ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       hit;
    logic       pinz;
    logic       exhausted;
    logic       none_avail;
    logic       wb;
    logic       scan_valid;
    logic       scan_last;
    logic       out_free;
  } stat_t;

endpackage

// File: hdl/pbpm_ctrl.sv
`timescale 1ns / 1ps
module pbpm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  pbpm_pkg::stat_t st,
  output pbpm_pkg::ctl_t  ctl
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOOK  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_TAKE  = 4'd3;
  localparam logic [3:0] S_WB    = 4'd4;
  localparam logic [3:0] S_INST  = 4'd5;
  localparam logic [3:0] S_FLUSH = 4'd6;
  localparam logic [3:0] S_SCAN  = 4'd7;
  localparam logic [3:0] S_REPLY = 4'd8;

  logic [3:0] state, state_next;
  logic [2:0] rstatus, rstatus_next;
  logic [1:0] psel, psel_next;
  logic [1:0] fsel, fsel_next;

  assign item_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    rstatus <= rstatus_next;
    psel <= psel_next;
    fsel <= fsel_next;
  end

  always_comb begin
    state_next = state;
    rstatus_next = rstatus;
    psel_next = psel;
    fsel_next = fsel;
    ctl = '0;
    ctl.rstatus = rstatus;
    ctl.psel = psel;
    ctl.fsel = fsel;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          ctl.load_in = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        ctl.lookup = 1'b1;
        state_next = S_DISP;
      end
      S_DISP: begin
        state_next = S_REPLY;
        rstatus_next = pbpm_pkg::STS_OK;
        psel_next = pbpm_pkg::PSEL_IN;
        fsel_next = pbpm_pkg::FSEL_HIT;
        unique case (st.cmd)
          pbpm_pkg::CMD_NEW: begin
            psel_next = pbpm_pkg::PSEL_ZERO;
            fsel_next = pbpm_pkg::FSEL_ZERO;
            if (st.exhausted) begin
              rstatus_next = pbpm_pkg::STS_EXHAUSTED;
            end else if (st.none_avail) begin
              rstatus_next = pbpm_pkg::STS_NO_FRAME;
            end else begin
              state_next = S_TAKE;
            end
          end
          pbpm_pkg::CMD_FETCH: begin
            if (st.hit) begin
              ctl.op_hit = 1'b1;
            end else if (st.none_avail) begin
              rstatus_next = pbpm_pkg::STS_NO_FRAME;
              fsel_next = pbpm_pkg::FSEL_ZERO;
            end else begin
              state_next = S_TAKE;
            end
          end
          pbpm_pkg::CMD_UNPIN: begin
            if (!st.hit) begin
              rstatus_next = pbpm_pkg::STS_NOT_RES;
              fsel_next = pbpm_pkg::FSEL_ZERO;
            end else if (st.pinz) begin
              rstatus_next = pbpm_pkg::STS_NOT_PIN;
            end else begin
              ctl.op_unpin = 1'b1;
            end
          end
          pbpm_pkg::CMD_DELETE: begin
            if (!st.hit) begin
              fsel_next = pbpm_pkg::FSEL_ZERO;
            end else if (!st.pinz) begin
              rstatus_next = pbpm_pkg::STS_PINNED;
            end else begin
              ctl.op_delete = 1'b1;
            end
          end
          pbpm_pkg::CMD_FLUSH: begin
            if (!st.hit) begin
              rstatus_next = pbpm_pkg::STS_NOT_RES;
              fsel_next = pbpm_pkg::FSEL_ZERO;
            end else begin
              state_next = S_FLUSH;
            end
          end
          pbpm_pkg::CMD_FLALL: begin
            ctl.scan_clr = 1'b1;
            psel_next = pbpm_pkg::PSEL_ZERO;
            fsel_next = pbpm_pkg::FSEL_ZERO;
            state_next = S_SCAN;
          end
          default: begin
            psel_next = pbpm_pkg::PSEL_ZERO;
            fsel_next = pbpm_pkg::FSEL_ZERO;
          end
        endcase
      end
      S_TAKE: begin
        ctl.take = 1'b1;
        state_next = S_WB;
      end
      S_WB: begin
        if (!st.wb) begin
          state_next = S_INST;
        end else if (st.out_free) begin
          ctl.emit = 1'b1;
          ctl.esel = pbpm_pkg::ESEL_WB;
          state_next = S_INST;
        end
      end
      S_INST: begin
        if (st.out_free) begin
          ctl.emit = 1'b1;
          ctl.esel = pbpm_pkg::ESEL_REQ;
          rstatus_next = pbpm_pkg::STS_OK;
          psel_next = pbpm_pkg::PSEL_INST;
          fsel_next = pbpm_pkg::FSEL_VIC;
          state_next = S_REPLY;
        end
      end
      S_FLUSH: begin
        if (st.out_free) begin
          ctl.emit = 1'b1;
          ctl.esel = pbpm_pkg::ESEL_FLUSH;
          state_next = S_REPLY;
        end
      end
      S_SCAN: begin
        if (!st.scan_valid || st.out_free) begin
          ctl.emit = st.scan_valid;
          ctl.esel = pbpm_pkg::ESEL_SCAN;
          ctl.scan_inc = 1'b1;
          if (st.scan_last) begin
            state_next = S_REPLY;
          end
        end
      end
      S_REPLY: begin
        if (st.out_free) begin
          ctl.emit = 1'b1;
          ctl.esel = pbpm_pkg::ESEL_REPLY;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/pbpm_datapath.sv
`timescale 1ns / 1ps
module pbpm_datapath #(
  parameter int POOL_FRAMES = pbpm_pkg::POOL_FRAMES_DEF,
  parameter int PIN_BITS = pbpm_pkg::PIN_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  pbpm_pkg::ctl_t  ctl,
  output pbpm_pkg::stat_t st,
  input  logic [2:0]      command,
  input  logic [30:0]     page_number,
  input  logic            mark_dirty,
  input  logic            cfg_write,
  input  logic [0:0]      cfg_index,
  input  logic [4:0]      cfg_data,
  output logic            result_valid,
  input  logic            result_stall,
  output logic [1:0]      kind,
  output logic [2:0]      status,
  output logic [30:0]     result_page,
  output logic [3:0]      frame,
  output logic            last
);

  localparam int FW = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
  localparam int CW = $clog2(POOL_FRAMES + 1);
  localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

  logic [2:0]  cmd_r;
  logic [30:0] page_r;
  logic        mark_r;
  logic        hit_r, pinz_r, wb_r;
  logic [FW-1:0] hf_r, vf_r, idx;
  logic [30:0] wbpage_r, ipage_r;
  logic [4:0]  inst_count;
  logic [31:0] next_id;

  logic [30:0]         frame_page [POOL_FRAMES];
  logic                valid      [POOL_FRAMES];
  logic                dirty      [POOL_FRAMES];
  logic [PIN_BITS-1:0] pin        [POOL_FRAMES];
  logic [FW-1:0]       fq         [POOL_FRAMES];
  logic [FW-1:0]       lru        [POOL_FRAMES];
  logic [FW-1:0]       lru_next   [POOL_FRAMES];
  logic [FW-1:0]       fhead;
  logic [CW-1:0]       fcount, llen, llen_next;

  logic          lk_hit;
  logic [FW-1:0] lk_f;
  logic          vic_free;
  logic [FW-1:0] vic;
  logic [CW:0]   tail_sum;
  logic [FW-1:0] ftail;
  logic          rem_en, app_en, found;
  logic [FW-1:0] rem_f;
  logic [CW-1:0] len1;
  logic [4:0]    step;
  logic [30:0]   req_page;
  logic [1:0]    e_kind;
  logic [2:0]    e_status;
  logic [30:0]   e_page;
  logic [3:0]    e_frame;
  logic          e_last;
  logic          out_free;

  function automatic logic [3:0] fr4(input logic [31:0] v);
    return v[3:0];
  endfunction

  always_comb begin
    lk_hit = 1'b0;
    lk_f = '0;
    for (int f = POOL_FRAMES - 1; f >= 0; f--) begin
      if (valid[f] && frame_page[f] == page_r) begin
        lk_hit = 1'b1;
        lk_f = FW'(f);
      end
    end
  end

  assign vic_free = (fcount != '0);
  assign vic = vic_free ? fq[fhead] : lru[0];
  assign tail_sum = (CW+1)'(fhead) + (CW+1)'(fcount);
  assign ftail = (tail_sum >= (CW+1)'(POOL_FRAMES)) ?
                 FW'(tail_sum - (CW+1)'(POOL_FRAMES)) : FW'(tail_sum);
  assign step = (inst_count == 5'd0) ? 5'd1 : inst_count;
  assign req_page = (cmd_r == pbpm_pkg::CMD_NEW) ? next_id[30:0] : page_r;
  assign out_free = !result_valid || !result_stall;

  always_comb begin
    rem_en = 1'b0;
    rem_f = hf_r;
    app_en = 1'b0;
    if (ctl.op_hit || ctl.op_delete) begin
      rem_en = 1'b1;
    end else if (ctl.op_unpin && pin[hf_r] == PIN_BITS'(1)) begin
      rem_en = 1'b1;
      app_en = 1'b1;
    end else if (ctl.take && !vic_free) begin
      rem_en = 1'b1;
      rem_f = vic;
    end
  end

  always_comb begin
    found = 1'b0;
    for (int i = 0; i < POOL_FRAMES; i++) begin
      if (rem_en && CW'(i) < llen && lru[i] == rem_f) begin
        found = 1'b1;
      end
      lru_next[i] = lru[i];
      if (found && i + 1 < POOL_FRAMES) begin
        lru_next[i] = lru[(i + 1) % POOL_FRAMES];
      end
    end
    len1 = llen - CW'(found);
    llen_next = len1;
    if (app_en && len1 < CW'(POOL_FRAMES)) begin
      lru_next[FW'(len1)] = hf_r;
      llen_next = len1 + CW'(1);
    end
  end

  always_comb begin
    e_kind = pbpm_pkg::KIND_WRITE;
    e_status = pbpm_pkg::STS_OK;
    e_page = '0;
    e_frame = '0;
    e_last = 1'b0;
    unique case (ctl.esel)
      pbpm_pkg::ESEL_WB: begin
        e_page = wbpage_r;
        e_frame = fr4(32'(vf_r));
      end
      pbpm_pkg::ESEL_REQ: begin
        e_kind = (cmd_r == pbpm_pkg::CMD_NEW) ? pbpm_pkg::KIND_WRITE : pbpm_pkg::KIND_READ;
        e_page = req_page;
        e_frame = fr4(32'(vf_r));
      end
      pbpm_pkg::ESEL_FLUSH: begin
        e_page = page_r;
        e_frame = fr4(32'(hf_r));
      end
      pbpm_pkg::ESEL_SCAN: begin
        e_page = frame_page[idx];
        e_frame = fr4(32'(idx));
      end
      pbpm_pkg::ESEL_REPLY: begin
        e_kind = pbpm_pkg::KIND_REPLY;
        e_status = ctl.rstatus;
        e_last = 1'b1;
        unique case (ctl.psel)
          pbpm_pkg::PSEL_IN:   e_page = page_r;
          pbpm_pkg::PSEL_INST: e_page = ipage_r;
          default:             e_page = '0;
        endcase
        unique case (ctl.fsel)
          pbpm_pkg::FSEL_HIT: e_frame = fr4(32'(hf_r));
          pbpm_pkg::FSEL_VIC: e_frame = fr4(32'(vf_r));
          default:            e_frame = '0;
        endcase
      end
      default: begin
        e_page = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_r <= command;
      page_r <= page_number;
      mark_r <= mark_dirty;
    end
    if (ctl.lookup) begin
      hit_r <= lk_hit;
      hf_r <= lk_f;
      pinz_r <= (pin[lk_f] == '0);
    end
    if (ctl.take) begin
      vf_r <= vic;
      wb_r <= valid[vic] && dirty[vic];
      wbpage_r <= frame_page[vic];
    end
    if (ctl.emit && ctl.esel == pbpm_pkg::ESEL_REQ) begin
      frame_page[vf_r] <= req_page;
      ipage_r <= req_page;
    end
    if (ctl.emit) begin
      kind <= e_kind;
      status <= e_status;
      result_page <= e_page;
      frame <= e_frame;
      last <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < POOL_FRAMES; i++) begin
        valid[i] <= 1'b0;
        dirty[i] <= 1'b0;
        pin[i] <= '0;
        fq[i] <= FW'(i);
        lru[i] <= '0;
      end
      fhead <= '0;
      fcount <= CW'(POOL_FRAMES);
      llen <= '0;
      idx <= '0;
      inst_count <= 5'd1;
      next_id <= '0;
      result_valid <= 1'b0;
    end else begin
      lru <= lru_next;
      llen <= llen_next;
      if (ctl.emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (ctl.scan_clr) begin
        idx <= '0;
      end else if (ctl.scan_inc) begin
        idx <= idx + FW'(1);
      end
      if (cfg_write) begin
        if (cfg_index == pbpm_pkg::CFG_COUNT) begin
          inst_count <= cfg_data;
        end else begin
          next_id <= 32'(cfg_data[3:0]);
        end
      end
      if (ctl.take) begin
        valid[vic] <= 1'b0;
        dirty[vic] <= 1'b0;
        pin[vic] <= '0;
        if (vic_free) begin
          fhead <= (fhead == FW'(POOL_FRAMES - 1)) ? '0 : fhead + FW'(1);
          fcount <= fcount - CW'(1);
        end
      end
      if (ctl.op_hit && pin[hf_r] != PIN_MAX) begin
        pin[hf_r] <= pin[hf_r] + PIN_BITS'(1);
      end
      if (ctl.op_unpin) begin
        pin[hf_r] <= pin[hf_r] - PIN_BITS'(1);
        if (mark_r) begin
          dirty[hf_r] <= 1'b1;
        end
      end
      if (ctl.op_delete) begin
        valid[hf_r] <= 1'b0;
        dirty[hf_r] <= 1'b0;
        if (fcount < CW'(POOL_FRAMES)) begin
          fq[ftail] <= hf_r;
          fcount <= fcount + CW'(1);
        end
      end
      if (ctl.emit) begin
        if (ctl.esel == pbpm_pkg::ESEL_REQ) begin
          valid[vf_r] <= 1'b1;
          dirty[vf_r] <= 1'b0;
          pin[vf_r] <= PIN_BITS'(1);
          if (cmd_r == pbpm_pkg::CMD_NEW) begin
            next_id <= next_id + 32'(step);
          end
        end else if (ctl.esel == pbpm_pkg::ESEL_FLUSH) begin
          dirty[hf_r] <= 1'b0;
        end else if (ctl.esel == pbpm_pkg::ESEL_SCAN) begin
          dirty[idx] <= 1'b0;
        end
      end
    end
  end

  assign st.cmd = cmd_r;
  assign st.hit = hit_r;
  assign st.pinz = pinz_r;
  assign st.exhausted = next_id[31];
  assign st.none_avail = (fcount == '0) && (llen == '0);
  assign st.wb = wb_r;
  assign st.scan_valid = valid[idx];
  assign st.scan_last = (idx == FW'(POOL_FRAMES - 1));
  assign st.out_free = out_free;

endmodule

// File: hdl/page_buffer_pool_manager_core.sv
`timescale 1ns / 1ps
// Metadata manager for a pool of page frames with a FIFO free list and LRU eviction.
// One command is handled at a time: a command is taken only while the block is idle,
// then a state machine steps through a registered page table lookup, decision, frame
// take, disk requests and the reply, one result transfer per cycle through an output
// register while the result side does not stall. New and fetch miss always pass through
// the write-back state, whether or not a dirty write-back is sent, and a stall on the
// result side holds the state machine. Every command ends with exactly one reply
// transfer that has last set.
module page_buffer_pool_manager_core #(
  parameter int POOL_FRAMES = pbpm_pkg::POOL_FRAMES_DEF,
  parameter int PIN_BITS = pbpm_pkg::PIN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  command,
  input  logic [30:0] page_number,
  input  logic        mark_dirty,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [2:0]  status,
  output logic [30:0] result_page,
  output logic [3:0]  frame,
  output logic        last,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  pbpm_pkg::ctl_t  ctl;
  pbpm_pkg::stat_t st;

  pbpm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .st         (st),
    .ctl        (ctl)
  );

  pbpm_datapath #(
    .POOL_FRAMES (POOL_FRAMES),
    .PIN_BITS    (PIN_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .st           (st),
    .command      (command),
    .page_number  (page_number),
    .mark_dirty   (mark_dirty),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .status       (status),
    .result_page  (result_page),
    .frame        (frame),
    .last         (last)
  );

endmodule

// File: tb/sv/page_buffer_pool_manager_core_test.sv
`timescale 1ns / 1ps
module page_buffer_pool_manager_core_test;

  localparam logic [2:0] CMD_BAD6 = 3'd6;
  localparam logic [2:0] CMD_BAD7 = 3'd7;
  localparam int NFR = 16;
  localparam int PIN_MAX = 65535;
  localparam longint ID_MAX = 64'h7FFF_FFFF;
  localparam int NO_STATUS = -1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [2:0] command = pbpm_pkg::CMD_NEW;
  logic [30:0] page_number = '0;
  logic mark_dirty = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [1:0] kind;
  logic [2:0] status;
  logic [30:0] result_page;
  logic [3:0] frame;
  logic last;
  logic cfg_write = 1'b0;
  logic [0:0] cfg_index = pbpm_pkg::CFG_COUNT;
  logic [4:0] cfg_data = '0;

  page_buffer_pool_manager_core DUT (.*);

  always #5 clk = ~clk;

  typedef struct {
    logic [1:0] kind;
    logic [2:0] status;
    logic [30:0] page;
    logic [3:0] frame;
    logic last;
  } result_t;

  typedef struct {
    logic [2:0] cmd;
    logic [30:0] page;
    logic mark;
    int sts;
  } row_t;

  result_t pending[$];
  row_t rows[$];

  logic [4:0] inst_count;
  logic [30:0] fr_page[NFR];
  bit fr_valid[NFR];
  int fr_pin[NFR];
  bit fr_dirty[NFR];
  int free_list[$];
  int lru_list[$];
  longint alloc_id;

  int failures = 0;
  int items_sent = 0;
  int results_seen = 0;
  int snd_pct = 0;
  int rcv_pct = 0;
  bit hold_req = 0;
  int hold_cnt = 0;

  function automatic void add(logic [1:0] k, logic [2:0] s, logic [30:0] p, int f, int l);
    result_t r;
    r.kind = k;
    r.status = s;
    r.page = p;
    r.frame = f[3:0];
    r.last = l[0];
    pending = {pending, r};
  endfunction

  function automatic int find_frame(logic [30:0] p);
    for (int f = 0; f < NFR; f++) begin
      if (fr_valid[f] && fr_page[f] == p) return f;
    end
    return -1;
  endfunction

  function automatic void lru_drop(int f);
    for (int i = 0; i < lru_list.size(); i++) begin
      if (lru_list[i] == f) begin
        lru_list.delete(i);
        return;
      end
    end
  endfunction

  function automatic int claim_frame();
    int f;
    if (free_list.size() > 0) begin
      f = free_list[0];
      free_list.delete(0);
    end else if (lru_list.size() > 0) begin
      f = lru_list[0];
      lru_list.delete(0);
    end else begin
      return -1;
    end
    if (fr_valid[f] && fr_dirty[f]) begin
      add(pbpm_pkg::KIND_WRITE, pbpm_pkg::STS_OK, fr_page[f], f, 0);
    end
    fr_valid[f] = 0;
    fr_dirty[f] = 0;
    fr_pin[f] = 0;
    return f;
  endfunction

  function automatic void load_frame(int f, logic [30:0] p);
    fr_page[f] = p;
    fr_valid[f] = 1;
    fr_pin[f] = 1;
    fr_dirty[f] = 0;
  endfunction

  function automatic void pool_reset();
    inst_count = 5'd1;
    free_list.delete();
    lru_list.delete();
    for (int f = 0; f < NFR; f++) begin
      fr_valid[f] = 0;
      fr_pin[f] = 0;
      fr_dirty[f] = 0;
      free_list = {free_list, f};
    end
    alloc_id = 0;
  endfunction

  function automatic void pool_command(logic [2:0] c, logic [30:0] p, logic m, int tsts);
    int f;
    case (c)
      pbpm_pkg::CMD_NEW: begin
        if (alloc_id > ID_MAX) begin
          add(pbpm_pkg::KIND_REPLY, pbpm_pkg::STS_EXHAUSTED, '0, 0, 1);
        end else begin
          f = claim_frame();
          if (f < 0) begin
            add(pbpm_pkg::KIND_REPLY, pbpm_pkg::STS_NO_FRAME, '0, 0, 1);
          end else begin
            load_frame(f, alloc_id[30:0]);
            add(pbpm_pkg::KIND_WRITE, pbpm_pkg::STS_OK, alloc_id[30:0], f, 0);
            add(pbpm_pkg::KIND_REPLY, pbpm_pkg::STS_OK, alloc_id[30:0], f, 1);
            alloc_id += (inst_count == 0) ? 1 : inst_count;
          end
        end
      end
      pbpm_pkg::CMD_FETCH: begin
        f = find_frame(p);
        if (f >= 0) begin
          lru_drop(f);
          if (fr_pin[f] < PIN_MAX) fr_pin[f]++;
          add(pbpm_pkg::KIND_REPLY, pbpm_pkg::STS_OK, p, f, 1);
        end else begin
          f = claim_frame();
          if (f < 0) begin
            add(pbpm_pkg::KIND_REPLY, pbpm_pkg::STS_NO_FRAME, p, 0, 1);
          end else begin
            load_frame(f, p);
            add(pbpm_pkg::KIND_READ, pbpm_pkg::STS_OK, p, f, 0);
            add(pbpm_pkg::KIND_REPLY, pbpm_pkg::STS_OK, p, f, 1);
          end
        end
      end
      pbpm_pkg::CMD_UNPIN: begin
        f = find_frame(p);
        if (f < 0) begin
          add(pbpm_pkg::KIND_REPLY, pbpm_pkg::STS_NOT_RES, p, 0, 1);
        end else if (fr_pin[f] == 0) begin
          add(pbpm_pkg::KIND_REPLY, pbpm_pkg::STS_NOT_PIN, p, f, 1);
        end else begin
          if (m) fr_dirty[f] = 1;
          fr_pin[f]--;
          if (fr_pin[f] == 0) begin
            lru_drop(f);
            lru_list = {lru_list, f};
          end
          add(pbpm_pkg::KIND_REPLY, pbpm_pkg::STS_OK, p, f, 1);
        end
      end
      pbpm_pkg::CMD_DELETE: begin
        f = find_frame(p);
        if (f < 0) begin
          add(pbpm_pkg::KIND_REPLY, pbpm_pkg::STS_OK, p, 0, 1);
        end else if (fr_pin[f] != 0) begin
          add(pbpm_pkg::KIND_REPLY, pbpm_pkg::STS_PINNED, p, f, 1);
        end else begin
          lru_drop(f);
          fr_valid[f] = 0;
          fr_dirty[f] = 0;
          if (free_list.size() < NFR) free_list = {free_list, f};
          add(pbpm_pkg::KIND_REPLY, pbpm_pkg::STS_OK, p, f, 1);
        end
      end
      pbpm_pkg::CMD_FLUSH: begin
        f = find_frame(p);
        if (f < 0) begin
          add(pbpm_pkg::KIND_REPLY, pbpm_pkg::STS_NOT_RES, p, 0, 1);
        end else begin
          add(pbpm_pkg::KIND_WRITE, pbpm_pkg::STS_OK, p, f, 0);
          fr_dirty[f] = 0;
          add(pbpm_pkg::KIND_REPLY, pbpm_pkg::STS_OK, p, f, 1);
        end
      end
      pbpm_pkg::CMD_FLALL: begin
        for (int g = 0; g < NFR; g++) begin
          if (fr_valid[g]) begin
            add(pbpm_pkg::KIND_WRITE, pbpm_pkg::STS_OK, fr_page[g], g, 0);
            fr_dirty[g] = 0;
          end
        end
        add(pbpm_pkg::KIND_REPLY, pbpm_pkg::STS_OK, '0, 0, 1);
      end
      default: add(pbpm_pkg::KIND_REPLY, pbpm_pkg::STS_OK, '0, 0, 1);
    endcase
    if (tsts != NO_STATUS) pending[pending.size() - 1].status = tsts[2:0];
  endfunction

  always @(posedge clk) begin
    if (hold_req) begin
      hold_req <= 1'b0;
      hold_cnt <= 300;
      result_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < rcv_pct);
    end
  end

  always @(posedge clk) begin
    result_t e;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (pending.size() == 0) begin
        $error("result with nothing expected: kind %0d page %0d", kind, result_page);
        failures++;
      end else begin
        e = pending[0];
        pending.delete(0);
        if (kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, kind);
          failures++;
        end
        if (status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status);
          failures++;
        end
        if (result_page !== e.page) begin
          $error("result_page: expected %0d, got %0d", e.page, result_page);
          failures++;
        end
        if (frame !== e.frame) begin
          $error("frame: expected %0d, got %0d", e.frame, frame);
          failures++;
        end
        if (last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, last);
          failures++;
        end
      end
    end
  end

  task automatic send(logic [2:0] c, logic [30:0] p, logic m, int tsts);
    while ($urandom_range(0, 99) < snd_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    command <= c;
    page_number <= p;
    mark_dirty <= m;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pool_command(c, p, m, tsts);
    items_sent++;
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [4:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == pbpm_pkg::CFG_COUNT) begin
      inst_count = val;
    end else begin
      alloc_id = longint'(val[3:0]);
    end
    @(posedge clk);
  endtask

  function automatic logic [30:0] pick_page();
    int f;
    if ($urandom_range(0, 9) < 7) begin
      for (int t = 0; t < 8; t++) begin
        f = $urandom_range(0, NFR - 1);
        if (fr_valid[f]) return fr_page[f];
      end
    end
    if ($urandom_range(0, 9) == 0) return 31'($urandom);
    return 31'($urandom_range(0, 40));
  endfunction

  task automatic random_items(int count);
    int r;
    logic [2:0] c;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 12) c = pbpm_pkg::CMD_NEW;
      else if (r < 37) c = pbpm_pkg::CMD_FETCH;
      else if (r < 70) c = pbpm_pkg::CMD_UNPIN;
      else if (r < 82) c = pbpm_pkg::CMD_DELETE;
      else if (r < 91) c = pbpm_pkg::CMD_FLUSH;
      else if (r < 96) c = pbpm_pkg::CMD_FLALL;
      else c = (r < 98) ? CMD_BAD6 : CMD_BAD7;
      send(c, pick_page(), 1'($urandom), NO_STATUS);
    end
  endtask

  function automatic void row(logic [2:0] c, logic [30:0] p, logic m, int s);
    row_t r;
    r.cmd = c;
    r.page = p;
    r.mark = m;
    r.sts = s;
    rows = {rows, r};
  endfunction

  initial begin
    pool_reset();
    row(pbpm_pkg::CMD_UNPIN, 31'd5, 1'b0, pbpm_pkg::STS_NOT_RES);
    row(pbpm_pkg::CMD_FLUSH, 31'd5, 1'b0, pbpm_pkg::STS_NOT_RES);
    row(pbpm_pkg::CMD_DELETE, 31'd5, 1'b0, pbpm_pkg::STS_OK);
    row(CMD_BAD6, 31'd5, 1'b1, pbpm_pkg::STS_OK);
    row(CMD_BAD7, 31'h7FFF_FFFF, 1'b1, pbpm_pkg::STS_OK);
    row(pbpm_pkg::CMD_NEW, 31'd0, 1'b0, pbpm_pkg::STS_OK);
    row(pbpm_pkg::CMD_UNPIN, 31'd0, 1'b1, pbpm_pkg::STS_OK);
    row(pbpm_pkg::CMD_UNPIN, 31'd0, 1'b0, pbpm_pkg::STS_NOT_PIN);
    row(pbpm_pkg::CMD_FETCH, 31'h7FFF_FFFF, 1'b0, pbpm_pkg::STS_OK);
    row(pbpm_pkg::CMD_DELETE, 31'h7FFF_FFFF, 1'b0, pbpm_pkg::STS_PINNED);
    row(pbpm_pkg::CMD_FLUSH, 31'h7FFF_FFFF, 1'b0, pbpm_pkg::STS_OK);
    row(pbpm_pkg::CMD_FLALL, 31'd0, 1'b0, pbpm_pkg::STS_OK);
    row(pbpm_pkg::CMD_FETCH, 31'd0, 1'b0, pbpm_pkg::STS_OK);
    row(pbpm_pkg::CMD_UNPIN, 31'd0, 1'b1, pbpm_pkg::STS_OK);
    row(pbpm_pkg::CMD_DELETE, 31'd0, 1'b0, pbpm_pkg::STS_OK);
    for (int i = 0; i < 15; i++) row(pbpm_pkg::CMD_FETCH, 31'(100 + i), 1'b0, NO_STATUS);
    row(pbpm_pkg::CMD_FETCH, 31'd200, 1'b0, pbpm_pkg::STS_NO_FRAME);
    row(pbpm_pkg::CMD_NEW, 31'd0, 1'b0, pbpm_pkg::STS_NO_FRAME);
    for (int i = 0; i < 15; i++) begin
      row(pbpm_pkg::CMD_UNPIN, 31'(100 + i), 1'($urandom), NO_STATUS);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send(rows[i].cmd, rows[i].page, rows[i].mark, rows[i].sts);
    settle();

    write_reg(pbpm_pkg::CFG_COUNT, 5'd0);
    write_reg(pbpm_pkg::CFG_NUMBER, 5'd3);
    hold_req = 1;
    random_items(22);
    settle();

    write_reg(pbpm_pkg::CFG_COUNT, 5'd16);
    write_reg(pbpm_pkg::CFG_NUMBER, 5'd15);
    snd_pct = 57;
    random_items(22);
    settle();

    write_reg(pbpm_pkg::CFG_COUNT, 5'd5);
    write_reg(pbpm_pkg::CFG_NUMBER, 5'd9);
    snd_pct = 0;
    rcv_pct = 57;
    random_items(22);
    settle();

    write_reg(pbpm_pkg::CFG_COUNT, 5'($urandom_range(1, 31)));
    write_reg(pbpm_pkg::CFG_NUMBER, 5'($urandom_range(0, 15)));
    snd_pct = 20;
    rcv_pct = 20;
    random_items(22);
    settle();

    $display("Covered %0d commands and %0d result transfers over five register settings,",
             items_sent, results_seen);
    $display("including a full pool, evictions, write-backs and a long result hold-off.");
    if (failures == 0) begin
      $display("page_buffer_pool_manager_core_test passed");
    end else begin
      $display("page_buffer_pool_manager_core_test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("page_buffer_pool_manager_core_test failed");
    $finish;
  end

endmodule
